// ===== rtl/core/wsp_pkg.sv =====
// Package for the windowed site pattern counter.
// Holds the transaction types, base and pattern codes, and the classifier.
// It has no dependencies of its own.
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int unsigned POSITION_BITS = 28;
  localparam int unsigned NUM_PATTERNS  = 8;
  localparam int unsigned QUEUE_DEPTH   = 3;
  localparam int unsigned QIDX_BITS     = $clog2(QUEUE_DEPTH);

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [POSITION_BITS:0]   end_t;
  typedef logic [QIDX_BITS-1:0]     qidx_t;
  typedef pos_t [NUM_PATTERNS-1:0]  cnt_vec_t;

  localparam pos_t POS_MAX = '1;
  localparam end_t END_SAT = {1'b1, {POSITION_BITS{1'b0}}};

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CASE_BIT = 8'h20;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [2:0] PAT_SAME         = 3'd0;
  localparam logic [2:0] PAT_FIRST_DIFF   = 3'd1;
  localparam logic [2:0] PAT_SECOND_DIFF  = 3'd2;
  localparam logic [2:0] PAT_THIRD_DIFF   = 3'd3;
  localparam logic [2:0] PAT_ANCEST_DIFF  = 3'd4;
  localparam logic [2:0] PAT_BBAA         = 3'd5;
  localparam logic [2:0] PAT_BABA         = 3'd6;
  localparam logic [2:0] PAT_ABBA         = 3'd7;

  typedef enum logic {
    CFG_WINDOW_LENGTH = 1'b0,
    CFG_CPG_ENABLE    = 1'b1
  } cfg_index_e;

  typedef struct packed {
    logic [7:0] base_first;
    logic [7:0] base_second;
    logic [7:0] base_third;
    logic [7:0] base_ancestral;
    logic       keep;
    logic       last_column;
  } in_item_t;

  typedef struct packed {
    pos_t window_start;
    end_t window_end;
    pos_t count_same;
    pos_t count_first_differs;
    pos_t count_second_differs;
    pos_t count_third_differs;
    pos_t count_ancestral_differs;
    pos_t count_bbaa;
    pos_t count_baba;
    pos_t count_abba;
    logic final_result;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] code;
  } base_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
  } pattern_t;

  function automatic base_t base_code(logic [7:0] ch);
    base_t r;
    r.valid = 1'b1;
    r.code  = BASE_A;
    case (ch)
      CH_A, CH_A | CASE_BIT: r.code = BASE_A;
      CH_C, CH_C | CASE_BIT: r.code = BASE_C;
      CH_G, CH_G | CASE_BIT: r.code = BASE_G;
      CH_T, CH_T | CASE_BIT: r.code = BASE_T;
      default:               r.valid = 1'b0;
    endcase
    return r;
  endfunction

  // Bases are packed first, second, third, ancestral from the top byte down.
  function automatic pattern_t classify(logic [31:0] bases);
    pattern_t r;
    base_t    a;
    base_t    b;
    base_t    c;
    base_t    d;
    a = base_code(bases[31:24]);
    b = base_code(bases[23:16]);
    c = base_code(bases[15:8]);
    d = base_code(bases[7:0]);
    r.valid = 1'b1;
    r.slot  = PAT_SAME;
    if (!(a.valid && b.valid && c.valid && d.valid)) begin
      r.valid = 1'b0;
    end else if (a.code == b.code && b.code == c.code && c.code == d.code) begin
      r.slot = PAT_SAME;
    end else if (b.code == c.code && c.code == d.code) begin
      r.slot = PAT_FIRST_DIFF;
    end else if (a.code == c.code && c.code == d.code) begin
      r.slot = PAT_SECOND_DIFF;
    end else if (a.code == b.code && b.code == d.code) begin
      r.slot = PAT_THIRD_DIFF;
    end else if (a.code == b.code && b.code == c.code) begin
      r.slot = PAT_ANCEST_DIFF;
    end else if (a.code == b.code && c.code == d.code) begin
      r.slot = PAT_BBAA;
    end else if (a.code == c.code && b.code == d.code) begin
      r.slot = PAT_BABA;
    end else if (a.code == d.code && b.code == c.code) begin
      r.slot = PAT_ABBA;
    end else begin
      r.valid = 1'b0;
    end
    return r;
  endfunction

  function automatic out_item_t make_result(pos_t start, end_t stop, cnt_vec_t cnt,
                                            logic fin);
    out_item_t r;
    r.window_start            = start;
    r.window_end              = stop;
    r.count_same              = cnt[PAT_SAME];
    r.count_first_differs     = cnt[PAT_FIRST_DIFF];
    r.count_second_differs    = cnt[PAT_SECOND_DIFF];
    r.count_third_differs     = cnt[PAT_THIRD_DIFF];
    r.count_ancestral_differs = cnt[PAT_ANCEST_DIFF];
    r.count_bbaa              = cnt[PAT_BBAA];
    r.count_baba              = cnt[PAT_BABA];
    r.count_abba              = cnt[PAT_ABBA];
    r.final_result            = fin;
    return r;
  endfunction

endpackage

// ===== rtl/core/windowed_site_pattern_counter.sv =====
// Top level of the windowed site pattern counter.
// Depends on wsp_pkg for the transaction types, codes and the classifier.
//
// Usage: the input channel carries one alignment column per transaction and
// the output channel one closed window per transaction. Both channels use
// valid and stall. An accepted column lands in an input register; once the
// result queue has room the column is classified, the held column is
// counted, CpG masking is applied and up to two window results are written
// into a three-entry result queue, whose head drives the output.
// Throughput is one column per cycle while the result queue holds fewer
// than two results. The input side stalls only while the result queue holds
// two or more results, so a receiver that takes one result per cycle slows
// the block only after a last column that closes two windows.
// A stalled receiver holds the head of the queue steady, and the input
// stalls once the queue can no longer absorb two results.
// Reset empties the queue by clearing its count, and clears the stream state
// and both configuration registers. The configuration port is always ready;
// it must be written only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps

module windowed_site_pattern_counter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  wsp_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output wsp_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wsp_pkg::cfg_index_e            cfg_index_i,
  input  logic [wsp_pkg::POSITION_BITS-1:0] cfg_data_i
);

  wsp_pkg::pos_t        wlen_q;
  logic                 cpg_en_q;

  wsp_pkg::in_item_t    s1_q;
  logic                 s1_valid_q, s1_valid_d;

  logic [31:0]          held_q, held_d;
  logic                 hkeep_q, hkeep_d;
  logic                 hpres_q, hpres_d;
  wsp_pkg::pos_t        col_q, col_d;
  wsp_pkg::pos_t        wbeg_q, wbeg_d;
  wsp_pkg::cnt_vec_t    cnt_q, cnt_d;

  wsp_pkg::out_item_t   queue_q [wsp_pkg::QUEUE_DEPTH];
  wsp_pkg::out_item_t   queue_d [wsp_pkg::QUEUE_DEPTH];
  wsp_pkg::qidx_t       qcnt_q, qcnt_d;

  logic                 accept;
  logic                 adv;
  logic                 pop;
  logic [31:0]          cur_bases;
  wsp_pkg::pattern_t    pat_held;
  wsp_pkg::pattern_t    pat_cur;
  logic                 cpg_hit;
  logic                 mask;
  logic                 kept1;
  logic                 kept2;
  logic                 last;
  logic                 wlen_nz;
  wsp_pkg::end_t        end1;
  wsp_pkg::end_t        end2;
  wsp_pkg::end_t        span1;
  wsp_pkg::end_t        span2;
  wsp_pkg::end_t        end_r2;
  wsp_pkg::pos_t        col_sat1;
  wsp_pkg::pos_t        c1;
  wsp_pkg::pos_t        wb1;
  logic                 close1;
  logic                 close2;
  wsp_pkg::cnt_vec_t    mid;
  wsp_pkg::cnt_vec_t    fin;
  wsp_pkg::end_t        sum;
  logic                 inc1;
  logic                 inc2;
  wsp_pkg::out_item_t   res1;
  wsp_pkg::out_item_t   res2;
  wsp_pkg::out_item_t   push_a;
  logic [1:0]           push_n;
  wsp_pkg::qidx_t       base_idx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q   <= '0;
      cpg_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsp_pkg::CFG_WINDOW_LENGTH: wlen_q   <= cfg_data_i;
        wsp_pkg::CFG_CPG_ENABLE:    cpg_en_q <= cfg_data_i[0];
        default:                    ;
      endcase
    end
  end

  assign adv        = s1_valid_q && (qcnt_q <= wsp_pkg::qidx_t'(1));
  assign in_stall_o = s1_valid_q && !adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = (qcnt_q != '0) && !out_stall_i;

  assign out_valid_o = (qcnt_q != '0);
  assign out_item_o  = queue_q[0];

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    cur_bases = {s1_q.base_first, s1_q.base_second, s1_q.base_third, s1_q.base_ancestral};
    last      = s1_q.last_column;
    pat_held  = wsp_pkg::classify(held_q);
    pat_cur   = wsp_pkg::classify(cur_bases);

    cpg_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (held_q[8*i +: 8] == wsp_pkg::CH_C && cur_bases[8*i +: 8] == wsp_pkg::CH_G) begin
        cpg_hit = 1'b1;
      end
    end
    mask  = cpg_en_q && hpres_q && cpg_hit;
    kept1 = hkeep_q && !mask;
    kept2 = s1_q.keep && !mask;

    wlen_nz  = (wlen_q != '0);
    end1     = {1'b0, col_q} + wsp_pkg::end_t'(1);
    col_sat1 = (col_q == wsp_pkg::POS_MAX) ? wsp_pkg::POS_MAX : end1[wsp_pkg::POSITION_BITS-1:0];
    span1    = end1 - {1'b0, wbeg_q};
    close1   = hpres_q && wlen_nz && (span1 >= {1'b0, wlen_q});
    c1       = hpres_q ? col_sat1 : col_q;
    wb1      = close1 ? col_sat1 : wbeg_q;

    if (!hpres_q) begin
      end2 = end1;
    end else if (col_q == wsp_pkg::POS_MAX) begin
      end2 = wsp_pkg::END_SAT;
    end else begin
      end2 = {1'b0, col_q} + wsp_pkg::end_t'(2);
    end
    span2  = end2 - {1'b0, wbeg_q};
    close2 = last && wlen_nz &&
             (close1 ? (wlen_q == wsp_pkg::pos_t'(1)) : (span2 >= {1'b0, wlen_q}));
    if (close2) begin
      end_r2 = end2;
    end else if (end2 >= {1'b0, wsp_pkg::POS_MAX}) begin
      end_r2 = wsp_pkg::END_SAT;
    end else begin
      end_r2 = end2;
    end

    for (int k = 0; k < wsp_pkg::NUM_PATTERNS; k++) begin
      inc1   = hpres_q && kept1 && pat_held.valid && (pat_held.slot == 3'(k));
      inc2   = last && kept2 && pat_cur.valid && (pat_cur.slot == 3'(k));
      mid[k] = (inc1 && cnt_q[k] != wsp_pkg::POS_MAX) ? cnt_q[k] + wsp_pkg::pos_t'(1)
                                                      : cnt_q[k];
      sum    = {1'b0, cnt_q[k]} + wsp_pkg::end_t'(inc1) + wsp_pkg::end_t'(inc2);
      if (close1) begin
        fin[k] = wsp_pkg::pos_t'(inc2);
      end else if (sum > {1'b0, wsp_pkg::POS_MAX}) begin
        fin[k] = wsp_pkg::POS_MAX;
      end else begin
        fin[k] = sum[wsp_pkg::POSITION_BITS-1:0];
      end
    end

    res1   = wsp_pkg::make_result(wbeg_q, end1, mid, 1'b0);
    res2   = wsp_pkg::make_result(wb1, end_r2, fin, 1'b1);
    push_a = close1 ? res1 : res2;
    push_n = adv ? (2'(close1) + 2'(last)) : 2'd0;

    held_d  = held_q;
    hkeep_d = hkeep_q;
    hpres_d = hpres_q;
    col_d   = col_q;
    wbeg_d  = wbeg_q;
    cnt_d   = cnt_q;
    if (adv) begin
      if (last) begin
        held_d  = '0;
        hkeep_d = 1'b0;
        hpres_d = 1'b0;
        col_d   = '0;
        wbeg_d  = '0;
        cnt_d   = '0;
      end else begin
        held_d  = cur_bases;
        hkeep_d = kept2;
        hpres_d = 1'b1;
        col_d   = c1;
        wbeg_d  = wb1;
        cnt_d   = close1 ? '0 : mid;
      end
    end
  end

  always_comb begin
    base_idx = qcnt_q - wsp_pkg::qidx_t'(pop);
    for (int i = 0; i < wsp_pkg::QUEUE_DEPTH; i++) begin
      queue_d[i] = queue_q[i];
    end
    if (pop) begin
      for (int i = 0; i < wsp_pkg::QUEUE_DEPTH - 1; i++) begin
        queue_d[i] = queue_q[i+1];
      end
    end
    for (int i = 0; i < wsp_pkg::QUEUE_DEPTH; i++) begin
      if (push_n != 2'd0 && base_idx == wsp_pkg::qidx_t'(i)) begin
        queue_d[i] = push_a;
      end
      if (push_n == 2'd2 && base_idx + wsp_pkg::qidx_t'(1) == wsp_pkg::qidx_t'(i)) begin
        queue_d[i] = res2;
      end
    end
    qcnt_d = base_idx + wsp_pkg::qidx_t'(push_n);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      qcnt_q     <= '0;
      held_q     <= '0;
      hkeep_q    <= 1'b0;
      hpres_q    <= 1'b0;
      col_q      <= '0;
      wbeg_q     <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      qcnt_q     <= qcnt_d;
      held_q     <= held_d;
      hkeep_q    <= hkeep_d;
      hpres_q    <= hpres_d;
      col_q      <= col_d;
      wbeg_q     <= wbeg_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_item_i;
    end
    queue_q <= queue_d;
  end

endmodule

// ===== rtl/core/wsp_checker.sv =====
// Port-level checker for the windowed site pattern counter, bound to its top.
// Depends on wsp_pkg for the transaction types.
`timescale 1ns / 1ps

module wsp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  wsp_pkg::in_item_t                 in_item_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  wsp_pkg::out_item_t                out_item_o,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  wsp_pkg::cfg_index_e               cfg_index_i,
  input  logic [wsp_pkg::POSITION_BITS-1:0] cfg_data_i
);

  // A result transaction that is stalled stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction withdrawn while stalled");

  // A stalled result transaction keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  // The input only stalls when results are waiting to be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // Every reported window covers at least one column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.window_end > {1'b0, out_item_o.window_start})
    else $error("reported window is empty");

endmodule

bind windowed_site_pattern_counter wsp_checker u_wsp_checker (.*);
